FILE: rtl/split_text_console_cursor_top_macros.svh
// Assertion macros shared by the console writer.
// Each one checks an implication on the rising edge of clk and is held off during reset.
`ifndef SPLIT_TEXT_CONSOLE_CURSOR_TOP_MACROS_SVH
`define SPLIT_TEXT_CONSOLE_CURSOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/stcc_pkg.sv
package stcc_pkg;

	localparam int ADDR_W      = 11;
	localparam int VALUE_W     = 16;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int ROWCNT_W    = 5;
	localparam int COUNT_W     = 12;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_IGNORED   = 8'h15;
	localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ATTR = 2'd1;

	localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET  = 5'd14;
	localparam logic [ATTR_W-1:0]   COLOR_ATTR_RESET = 8'd15;

	typedef struct packed {
		logic               cell_write;
		logic [ADDR_W-1:0]  cell_address;
		logic [VALUE_W-1:0] cell_value;
		logic               pane_cleared;
		logic               cursor_write;
		logic [ADDR_W-1:0]  cursor_offset;
	} stcc_result_t;

endpackage

FILE: rtl/stcc_cursor.sv
module stcc_cursor #(
	parameter int LINE_WIDTH = 80,
	parameter int PANE_WIDTH = 40,
	parameter int MAX_ROWS   = 16,
	parameter int TAB_STEP   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              pane,
	input  logic [stcc_pkg::CHAR_W-1:0]       char_code,
	input  logic [stcc_pkg::ROWCNT_W-1:0]     row_count,
	input  logic [stcc_pkg::ATTR_W-1:0]       color_attr,
	output stcc_pkg::stcc_result_t            result
);

	localparam int CW    = $clog2(LINE_WIDTH);
	localparam int NW    = $clog2(LINE_WIDTH + TAB_STEP);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CMP_W = (RW > stcc_pkg::ROWCNT_W) ? RW : stcc_pkg::ROWCNT_W;
	localparam int AW    = stcc_pkg::ADDR_W;

	logic [CW-1:0] lcol_q, rcol_q;
	logic [RW-1:0] lrow_q, rrow_q;
	logic [stcc_pkg::COUNT_W-1:0] lcnt_q, rcnt_q;

	// Next tab stop for every column, fixed at elaboration.
	logic [NW-1:0] tab_next [LINE_WIDTH];
	for (genvar g = 0; g < LINE_WIDTH; g++) begin : g_tab
		assign tab_next[g] = NW'(g - (g % TAB_STEP) + TAB_STEP);
	end

	logic [CW-1:0] col_cur, col_n;
	logic [RW-1:0] row_cur, row_n, row_inc, row_wrap, limit, row_addr;
	logic [stcc_pkg::COUNT_W-1:0] cnt_cur, cnt_n, cnt_inc;
	logic [NW-1:0] home, edge_col, col_ext, col_adv, tab_col;
	logic [CW-1:0] col_addr;
	logic nl_clear, wr, clr, mv, mv_ok;
	logic [stcc_pkg::VALUE_W-1:0] val;

	always_comb begin
		limit = (CMP_W'(row_count) < CMP_W'(MAX_ROWS)) ? RW'(row_count) : RW'(MAX_ROWS);
		col_cur  = pane ? rcol_q : lcol_q;
		row_cur  = pane ? rrow_q : lrow_q;
		cnt_cur  = pane ? rcnt_q : lcnt_q;
		home     = pane ? NW'(PANE_WIDTH) : '0;
		edge_col = pane ? NW'(LINE_WIDTH) : NW'(PANE_WIDTH);
		col_ext  = NW'(col_cur);
		col_adv  = col_ext + NW'(1);
		tab_col  = tab_next[col_cur];
		cnt_inc  = (cnt_cur == stcc_pkg::COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

		// Start of the next row, wrapping to the top once the row limit is reached.
		row_inc  = row_cur + 1'b1;
		nl_clear = (row_inc >= limit);
		row_wrap = nl_clear ? '0 : row_inc;

		col_n    = col_cur;
		row_n    = row_cur;
		cnt_n    = cnt_cur;
		wr       = 1'b0;
		clr      = 1'b0;
		mv       = 1'b0;
		val      = '0;
		col_addr = col_cur;
		row_addr = row_cur;

		case (char_code)
			stcc_pkg::CHAR_NEWLINE: begin
				col_n = CW'(home);
				row_n = row_wrap;
				clr   = nl_clear;
				cnt_n = '0;
				mv    = 1'b1;
			end
			stcc_pkg::CHAR_IGNORED: begin
			end
			stcc_pkg::CHAR_BACKSPACE: begin
				if (cnt_cur != '0) begin
					if (col_ext <= home) begin
						col_n = CW'(edge_col - NW'(1));
						row_n = (row_cur != '0) ? row_cur - 1'b1 : row_cur;
					end else begin
						col_n = col_cur - 1'b1;
					end
					// The blanked cell is the one the cursor lands on.
					col_addr = col_n;
					row_addr = row_n;
					mv       = 1'b1;
					wr       = 1'b1;
					val      = {color_attr, stcc_pkg::CHAR_BLANK};
					cnt_n    = cnt_cur - 1'b1;
				end
			end
			stcc_pkg::CHAR_TAB: begin
				if (tab_col >= edge_col) begin
					col_n = CW'(home);
					row_n = row_wrap;
					clr   = nl_clear;
				end else begin
					col_n = CW'(tab_col);
				end
				mv    = 1'b1;
				cnt_n = cnt_inc;
			end
			default: begin
				wr  = 1'b1;
				val = {color_attr, char_code};
				if (col_adv >= edge_col) begin
					col_n = CW'(home);
					row_n = row_wrap;
					clr   = nl_clear;
				end else begin
					col_n = CW'(col_adv);
				end
				mv    = 1'b1;
				cnt_n = cnt_inc;
			end
		endcase

		mv_ok = mv && (NW'(col_n) < NW'(LINE_WIDTH)) && (row_n < limit);

		result.cell_write    = wr;
		result.cell_address  = wr ? AW'(row_addr) * AW'(LINE_WIDTH) + AW'(col_addr) : '0;
		result.cell_value    = val;
		result.pane_cleared  = clr;
		result.cursor_write  = mv_ok;
		result.cursor_offset = mv_ok ? AW'(row_n) * AW'(LINE_WIDTH) + AW'(col_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcol_q <= '0;
			lrow_q <= '0;
			lcnt_q <= '0;
			rcol_q <= CW'(PANE_WIDTH);
			rrow_q <= '0;
			rcnt_q <= '0;
		end else if (step) begin
			if (pane) begin
				rcol_q <= col_n;
				rrow_q <= row_n;
				rcnt_q <= cnt_n;
			end else begin
				lcol_q <= col_n;
				lrow_q <= row_n;
				lcnt_q <= cnt_n;
			end
		end
	end

endmodule

FILE: rtl/split_text_console_cursor_top.sv
// Pipeline: an accepted item sits in the input register, and its result is loaded into
// the result register when the output is free, which sets out_valid.
// Throughput: one item per cycle while out_ready does not stall the output; the cursor
// update for an item is registered with its result, so the next item sees the new cursor state at once.
// Reset clears the pipeline valids, homes both pane cursors and restores row_count 14
// and color_attr 15.
`include "split_text_console_cursor_top_macros.svh"

module split_text_console_cursor_top #(
	parameter int LINE_WIDTH = 80,
	parameter int PANE_WIDTH = 40,
	parameter int MAX_ROWS   = 16,
	parameter int TAB_STEP   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                pane,
	input  logic [stcc_pkg::CHAR_W-1:0]         char_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                cell_write,
	output logic [stcc_pkg::ADDR_W-1:0]         cell_address,
	output logic [stcc_pkg::VALUE_W-1:0]        cell_value,
	output logic                                pane_cleared,
	output logic                                cursor_write,
	output logic [stcc_pkg::ADDR_W-1:0]         cursor_offset,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data
);

	logic v_s1;
	logic pane_s1;
	logic [stcc_pkg::CHAR_W-1:0] char_s1;
	logic out_valid_q;
	logic [stcc_pkg::ROWCNT_W-1:0] row_count_q;
	logic [stcc_pkg::ATTR_W-1:0] color_attr_q;
	stcc_pkg::stcc_result_t res_c, res_q;
	logic out_free, s1_adv;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_adv    = v_s1 && out_free;
	assign in_ready  = !v_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
			row_count_q  <= stcc_pkg::ROW_COUNT_RESET;
			color_attr_q <= stcc_pkg::COLOR_ATTR_RESET;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= v_s1;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					stcc_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_data[stcc_pkg::ROWCNT_W-1:0];
					stcc_pkg::REG_COLOR_ATTR: color_attr_q <= cfg_data[stcc_pkg::ATTR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pane_s1 <= pane;
			char_s1 <= char_code;
		end
		if (s1_adv) begin
			res_q <= res_c;
		end
	end

	stcc_cursor #(
		.LINE_WIDTH(LINE_WIDTH),
		.PANE_WIDTH(PANE_WIDTH),
		.MAX_ROWS  (MAX_ROWS),
		.TAB_STEP  (TAB_STEP)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_adv),
		.pane      (pane_s1),
		.char_code (char_s1),
		.row_count (row_count_q),
		.color_attr(color_attr_q),
		.result    (res_c)
	);

	assign out_valid     = out_valid_q;
	assign cell_write    = res_q.cell_write;
	assign cell_address  = res_q.cell_address;
	assign cell_value    = res_q.cell_value;
	assign pane_cleared  = res_q.pane_cleared;
	assign cursor_write  = res_q.cursor_write;
	assign cursor_offset = res_q.cursor_offset;

	`STCC_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready, "input stalled with empty output")
	`STCC_ASSERT_NEXT(a_accept_loads_s1, in_valid && in_ready, v_s1, "accepted item not held")
	`STCC_ASSERT_NOW(a_no_write_zero, out_valid_q && !res_q.cell_write, (res_q.cell_address == '0) && (res_q.cell_value == '0), "cell fields not zero without a write")
	`STCC_ASSERT_NOW(a_no_cursor_zero, out_valid_q && !res_q.cursor_write, res_q.cursor_offset == '0, "cursor offset not zero without an update")

endmodule

FILE: verif/split_text_console_cursor_top_tb.sv
module split_text_console_cursor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_W   = 80;
	localparam int PANE_W   = 40;
	localparam int MAX_ROWS = 16;
	localparam int TAB_STEP = 8;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int LONG_LINE      = 90;

	// Indexes that map to no register; a write to them must change nothing.
	localparam logic [stcc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [stcc_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_3 = 2'd3;

	typedef struct packed {
		logic                        right_pane;
		logic [stcc_pkg::CHAR_W-1:0] code;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             pane = 1'b0;
	logic [stcc_pkg::CHAR_W-1:0]      char_code = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             cell_write;
	logic [stcc_pkg::ADDR_W-1:0]      cell_address;
	logic [stcc_pkg::VALUE_W-1:0]     cell_value;
	logic                             pane_cleared;
	logic                             cursor_write;
	logic [stcc_pkg::ADDR_W-1:0]      cursor_offset;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [stcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]                       cfg_data = '0;

	// Shadow copy of the console state and its registers.
	logic [6:0]                    pane_col [2] = '{7'd0, 7'(PANE_W)};
	logic [3:0]                    pane_row [2] = '{4'd0, 4'd0};
	logic [stcc_pkg::COUNT_W-1:0]  line_count [2] = '{'0, '0};
	logic [stcc_pkg::ROWCNT_W-1:0] row_cfg = stcc_pkg::ROW_COUNT_RESET;
	logic [stcc_pkg::ATTR_W-1:0]   attr_cfg = stcc_pkg::COLOR_ATTR_RESET;

	char_item_t             char_queue [$];
	stcc_pkg::stcc_result_t pending_cells [$];

	int unsigned items_queued = 0;
	int unsigned results_checked = 0;
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	bit          calm = 1'b0;

	split_text_console_cursor_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pane         (pane),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cell_write   (cell_write),
		.cell_address (cell_address),
		.cell_value   (cell_value),
		.pane_cleared (pane_cleared),
		.cursor_write (cursor_write),
		.cursor_offset(cursor_offset),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned draw_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Start of the next row; true when the row reaches the limit and the pane is blanked.
	function automatic bit take_new_line(inout int c, inout int r, input int home, input int limit);
		c = home;
		r = r + 1;
		if (r >= limit) begin
			r = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic stcc_pkg::stcc_result_t advance_cursor(input logic p,
			input logic [stcc_pkg::CHAR_W-1:0] ch);
		stcc_pkg::stcc_result_t res;
		int c, r, cnt, home, right_edge, limit;
		bit moved;
		res = '0;
		moved = 1'b0;
		c = pane_col[p];
		r = pane_row[p];
		cnt = line_count[p];
		home = p ? PANE_W : 0;
		right_edge = p ? LINE_W : PANE_W;
		limit = (row_cfg < MAX_ROWS) ? int'(row_cfg) : MAX_ROWS;
		case (ch)
			stcc_pkg::CHAR_NEWLINE: begin
				res.pane_cleared = take_new_line(c, r, home, limit);
				cnt = 0;
				moved = 1'b1;
			end
			stcc_pkg::CHAR_IGNORED: ;
			stcc_pkg::CHAR_BACKSPACE: begin
				if (cnt != 0) begin
					if (c <= home) begin
						c = right_edge - 1;
						if (r > 0)
							r = r - 1;
					end else begin
						c = c - 1;
					end
					moved = 1'b1;
					res.cell_write = 1'b1;
					res.cell_address = stcc_pkg::ADDR_W'(r * LINE_W + c);
					res.cell_value = {attr_cfg, stcc_pkg::CHAR_BLANK};
					cnt = cnt - 1;
				end
			end
			stcc_pkg::CHAR_TAB: begin
				c = c - (c % TAB_STEP) + TAB_STEP;
				if (c >= right_edge)
					res.pane_cleared = take_new_line(c, r, home, limit);
				moved = 1'b1;
				if (cnt < stcc_pkg::COUNT_MAX)
					cnt = cnt + 1;
			end
			default: begin
				res.cell_write = 1'b1;
				res.cell_address = stcc_pkg::ADDR_W'(r * LINE_W + c);
				res.cell_value = {attr_cfg, ch};
				c = c + 1;
				if (c >= right_edge)
					res.pane_cleared = take_new_line(c, r, home, limit);
				moved = 1'b1;
				if (cnt < stcc_pkg::COUNT_MAX)
					cnt = cnt + 1;
			end
		endcase
		// The cursor register only follows a cursor that is on the visible rows.
		if (moved && c < LINE_W && r < limit) begin
			res.cursor_write = 1'b1;
			res.cursor_offset = stcc_pkg::ADDR_W'(r * LINE_W + c);
		end
		pane_col[p] = 7'(c);
		pane_row[p] = 4'(r);
		line_count[p] = stcc_pkg::COUNT_W'(cnt);
		return res;
	endfunction

	// Control codes make up ctrl_pct percent; other bytes are raw, or any byte but the four control codes.
	function automatic logic [stcc_pkg::CHAR_W-1:0] pick_code(input int unsigned ctrl_pct,
			input bit raw_bytes);
		int unsigned roll;
		logic [stcc_pkg::CHAR_W-1:0] code;
		roll = $urandom_range(0, 99);
		if (roll < ctrl_pct) begin
			roll = $urandom_range(0, 9);
			if (roll < 5)
				return stcc_pkg::CHAR_BACKSPACE;
			if (roll < 8)
				return stcc_pkg::CHAR_TAB;
			if (roll < 9)
				return stcc_pkg::CHAR_NEWLINE;
			return stcc_pkg::CHAR_IGNORED;
		end
		code = stcc_pkg::CHAR_W'($urandom_range(0, 255));
		while (!raw_bytes && (code == stcc_pkg::CHAR_BACKSPACE || code == stcc_pkg::CHAR_TAB ||
				code == stcc_pkg::CHAR_NEWLINE || code == stcc_pkg::CHAR_IGNORED))
			code = stcc_pkg::CHAR_W'($urandom_range(0, 255));
		return code;
	endfunction

	task automatic queue_char(input logic p, input logic [stcc_pkg::CHAR_W-1:0] code);
		char_queue.push_back('{right_pane: p, code: code});
		items_queued++;
	endtask

	// Random traffic: mostly runs of text on one pane, the rest single noise items.
	task automatic queue_random_mix(input int unsigned target);
		int unsigned first;
		int unsigned run_len;
		logic p;
		first = items_queued;
		while (items_queued - first < target) begin
			p = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) begin
				queue_char(p, pick_code(45, 1'b1));
			end else begin
				run_len = $urandom_range(4, 70);
				repeat (run_len)
					queue_char(p, pick_code(25, $urandom_range(0, 3) == 0));
			end
		end
	endtask

	task automatic wait_idle();
		while (results_checked != items_queued)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [stcc_pkg::CFG_INDEX_W-1:0] idx,
			input logic [7:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			stcc_pkg::REG_ROW_COUNT:  row_cfg = data[stcc_pkg::ROWCNT_W-1:0];
			stcc_pkg::REG_COLOR_ATTR: attr_cfg = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input int unsigned rows, input logic [7:0] attr);
		wait_idle();
		write_reg(stcc_pkg::REG_ROW_COUNT, 8'(rows));
		write_reg(stcc_pkg::REG_COLOR_ATTR, attr);
	endtask

	// Driver: presents queued items, holding each one until it is taken.
	always @(posedge clk) begin
		char_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				pending_cells.push_back(advance_cursor(pane, char_code));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (char_queue.size() > 0) begin
					item = char_queue.pop_front();
					in_valid <= 1'b1;
					pane <= item.right_pane;
					char_code <= item.code;
					send_gap = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Monitor: stalls the result side at random and checks each result in order.
	always @(posedge clk) begin
		stcc_pkg::stcc_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (pending_cells.size() == 0) begin
					$error("result arrived with no item waiting for it");
					error_count++;
				end else begin
					want = pending_cells.pop_front();
					check_field("cell_write", want.cell_write, cell_write);
					check_field("cell_address", want.cell_address, cell_address);
					check_field("cell_value", want.cell_value, cell_value);
					check_field("pane_cleared", want.pane_cleared, pane_cleared);
					check_field("cursor_write", want.cursor_write, cursor_write);
					check_field("cursor_offset", want.cursor_offset, cursor_offset);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					stall_left = draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: raw byte extremes, tabs on both panes, the ignored byte,
		// backspace after a newline, a right-pane tab that wraps at the line end,
		// and a backspace at the pane's home column stepping to the row above.
		queue_char(1'b0, 8'h41);
		queue_char(1'b0, 8'h00);
		queue_char(1'b0, 8'hFF);
		queue_char(1'b1, 8'h7E);
		queue_char(1'b0, stcc_pkg::CHAR_TAB);
		queue_char(1'b1, stcc_pkg::CHAR_TAB);
		queue_char(1'b0, stcc_pkg::CHAR_IGNORED);
		queue_char(1'b0, stcc_pkg::CHAR_BACKSPACE);
		queue_char(1'b0, stcc_pkg::CHAR_NEWLINE);
		queue_char(1'b0, stcc_pkg::CHAR_BACKSPACE);
		repeat (4) queue_char(1'b1, stcc_pkg::CHAR_TAB);
		queue_char(1'b1, stcc_pkg::CHAR_BACKSPACE);
		queue_char(1'b1, stcc_pkg::CHAR_BLANK);

		// One row: every newline and tab wrap clears; backspace at the top stays on row 0.
		set_config(1, 8'hFF);
		queue_char(1'b0, stcc_pkg::CHAR_NEWLINE);
		repeat (5) queue_char(1'b0, stcc_pkg::CHAR_TAB);
		queue_char(1'b0, stcc_pkg::CHAR_BACKSPACE);

		// Zero rows: the cursor is never on a visible row.
		set_config(0, 8'h00);
		write_reg(REG_UNMAPPED_2, 8'h5A);
		write_reg(REG_UNMAPPED_3, 8'hA5);
		queue_char(1'b0, 8'h61);
		queue_char(1'b1, stcc_pkg::CHAR_NEWLINE);

		set_config(MAX_ROWS, 8'($urandom_range(0, 255)));
		queue_random_mix(120);
		set_config(31, 8'hFF);
		queue_random_mix(100);
		set_config(1, 8'($urandom_range(0, 255)));
		queue_random_mix(70);
		set_config(0, 8'($urandom_range(0, 255)));
		queue_random_mix(40);
		set_config($urandom_range(2, 15), 8'($urandom_range(0, 255)));
		queue_random_mix(110);

		// A line that wraps over several rows, then backspaces back across the
		// wraps until one is ignored, sent back to back.
		set_config(MAX_ROWS, 8'($urandom_range(0, 255)));
		calm = 1'b1;
		queue_char(1'b1, stcc_pkg::CHAR_NEWLINE);
		repeat (LONG_LINE) queue_char(1'b1, pick_code(0, 1'b0));
		repeat (LONG_LINE + 1) queue_char(1'b1, stcc_pkg::CHAR_BACKSPACE);
		wait_idle();
		calm = 1'b0;

		set_config($urandom_range(1, 16), 8'h00);
		queue_random_mix(90);
		set_config($urandom_range(1, 31), 8'($urandom_range(0, 255)));
		queue_random_mix(70);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_cells.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/stcc_pkg.sv
rtl/stcc_cursor.sv
rtl/split_text_console_cursor_top.sv
verif/split_text_console_cursor_top_tb.sv
